### src/pfc_pkg.sv
// Format codes and conversion functions for the pixel format cast block.
package pfc_pkg;

   localparam logic [3:0] FMT_U8  = 4'd0;
   localparam logic [3:0] FMT_S8  = 4'd1;
   localparam logic [3:0] FMT_U16 = 4'd2;
   localparam logic [3:0] FMT_S16 = 4'd3;
   localparam logic [3:0] FMT_U32 = 4'd4;
   localparam logic [3:0] FMT_S32 = 4'd5;
   localparam logic [3:0] FMT_F32 = 4'd6;
   localparam logic [3:0] FMT_F64 = 4'd7;
   localparam logic [3:0] FMT_C32 = 4'd8;
   localparam logic [3:0] FMT_C64 = 4'd9;

   localparam logic [1:0] REG_SOURCE_FORMAT = 2'd0;
   localparam logic [1:0] REG_TARGET_FORMAT = 2'd1;
   localparam logic [1:0] REG_SHIFT_MODE    = 2'd2;

   typedef logic signed [33:0] ival_type;

   function automatic logic [5:0] int_width(input logic [3:0] f);
      logic [5:0] w;
      unique case (f)
         FMT_U8, FMT_S8:   w = 6'd8;
         FMT_U16, FMT_S16: w = 6'd16;
         default:          w = 6'd32;
      endcase
      return w;
   endfunction

   function automatic logic [31:0] int_mask(input logic [3:0] f);
      logic [31:0] m;
      unique case (f)
         FMT_U8, FMT_S8:   m = 32'h0000_00FF;
         FMT_U16, FMT_S16: m = 32'h0000_FFFF;
         default:          m = 32'hFFFF_FFFF;
      endcase
      return m;
   endfunction

   function automatic ival_type int_value(input logic [3:0] f, input logic [63:0] b);
      ival_type v;
      unique case (f)
         FMT_U8:  v = {26'b0, b[7:0]};
         FMT_S8:  v = {{26{b[7]}}, b[7:0]};
         FMT_U16: v = {18'b0, b[15:0]};
         FMT_S16: v = {{18{b[15]}}, b[15:0]};
         FMT_S32: v = {{2{b[31]}}, b[31:0]};
         default: v = {2'b0, b[31:0]};
      endcase
      return v;
   endfunction

   // saturate a value to an integer format's range
   function automatic logic [63:0] clamp_int(input ival_type v, input logic [3:0] f);
      ival_type lo, hi, r;
      unique case (f)
         FMT_U8:  begin lo = 34'sd0;           hi = 34'sd255;        end
         FMT_S8:  begin lo = -34'sd128;        hi = 34'sd127;        end
         FMT_U16: begin lo = 34'sd0;           hi = 34'sd65535;      end
         FMT_S16: begin lo = -34'sd32768;      hi = 34'sd32767;      end
         FMT_S32: begin lo = -34'sd2147483648; hi = 34'sd2147483647; end
         default: begin lo = 34'sd0;           hi = 34'sd4294967295; end
      endcase
      if (v < lo) r = lo;
      else if (v > hi) r = hi;
      else r = v;
      return {32'b0, r[31:0] & int_mask(f)};
   endfunction

   function automatic logic [63:0] int_to_int(input logic [3:0] sf, input logic [3:0] tf,
                                              input logic shift, input logic [63:0] b);
      logic [5:0]  wi, wo, n;
      logic [63:0] u, mo, r;
      wi = int_width(sf);
      wo = int_width(tf);
      mo = {32'b0, int_mask(tf)};
      u  = {32'b0, b[31:0] & int_mask(sf)};
      n  = 6'd0;
      if (shift) begin
         if (wi > wo) begin
            r = (u >> (wi - wo)) & mo;
         end else begin
            n = wo - wi;
            r = u << n;
            if (u[0]) r = r | ((64'd1 << n) - 64'd1);
            r = r & mo;
         end
      end else begin
         r = clamp_int(int_value(sf, b), tf);
      end
      return r;
   endfunction

   function automatic logic [63:0] int_to_f64(input ival_type v);
      logic [32:0] mag;
      logic [5:0]  p;
      logic [51:0] fm;
      mag = v[33] ? 33'(-v) : v[32:0];
      p = 6'd0;
      for (int i = 0; i < 33; i++) if (mag[i]) p = 6'(i);
      fm = 52'({19'b0, mag} << (6'd52 - p));
      if (mag == 33'd0) return 64'd0;
      return {v[33], 11'd1023 + {5'b0, p}, fm};
   endfunction

   function automatic logic [63:0] widen_f32(input logic [31:0] b);
      logic        s;
      logic [7:0]  e;
      logic [22:0] m;
      logic [5:0]  p;
      logic [51:0] fm;
      logic [63:0] r;
      s = b[31];
      e = b[30:23];
      m = b[22:0];
      p = 6'd0;
      for (int i = 0; i < 23; i++) if (m[i]) p = 6'(i);
      fm = 52'({29'b0, m} << (6'd52 - p));
      if (e == 8'hFF) begin
         if (m != 23'd0) r = {s, 11'h7FF, 1'b1, m[21:0], 29'b0};
         else r = {s, 11'h7FF, 52'b0};
      end else if (e == 8'd0) begin
         // subnormal single is normal in double
         if (m == 23'd0) r = {s, 63'b0};
         else r = {s, 11'd874 + {5'b0, p}, fm};
      end else begin
         r = {s, {3'b0, e} + 11'd896, m, 29'b0};
      end
      return r;
   endfunction

   function automatic logic [31:0] narrow_f64(input logic [63:0] b);
      logic         s;
      logic [10:0]  e, shw;
      logic [51:0]  m;
      logic [5:0]   sh;
      logic [116:0] x;
      logic [31:0]  r;
      logic         g, st;
      s   = b[63];
      e   = b[62:52];
      m   = b[51:0];
      shw = 11'd926 - e;
      sh  = (shw > 11'd63) ? 6'd63 : shw[5:0];
      x   = {1'b1, m, 64'b0} >> sh;
      g   = 1'b0;
      st  = 1'b0;
      if (e == 11'h7FF) begin
         r = {s, 8'hFF, m[51:29] | 23'h40_0000};
         if (m == 52'd0) r = {s, 8'hFF, 23'b0};
      end else if (e >= 11'd1151) begin
         r = {s, 8'hFF, 23'b0};
      end else if (e >= 11'd897) begin
         // carry out of the mantissa bumps the exponent, up to infinity
         g  = m[28];
         st = |m[27:0];
         r  = {s, 8'(e - 11'd896), m[51:29]} + {31'b0, g & (st | m[29])};
      end else if (e == 11'd0) begin
         r = {s, 31'b0};
      end else begin
         g  = x[63];
         st = |x[62:0];
         r  = {s, 8'b0, x[86:64]} + {31'b0, g & (st | x[64])};
      end
      return r;
   endfunction

   function automatic logic [63:0] f64_to_int(input logic [63:0] b, input logic [3:0] tf);
      logic        s;
      logic [10:0] e;
      logic [51:0] m;
      logic [32:0] mag;
      logic [5:0]  sh;
      ival_type    v;
      s   = b[63];
      e   = b[62:52];
      m   = b[51:0];
      sh  = 6'(11'd1075 - e);
      mag = 33'({1'b1, m} >> sh);
      if (e < 11'd1023) mag = 33'd0;
      else if (e >= 11'd1055) mag = 33'h1_0000_0000;
      v = s ? -{1'b0, mag} : {1'b0, mag};
      if (e == 11'h7FF && m != 52'd0) return 64'd0;
      return clamp_int(v, tf);
   endfunction

   function automatic logic [63:0] src_double(input logic [3:0] sf, input logic [63:0] b);
      logic [63:0] r;
      if (sf < FMT_F32) r = int_to_f64(int_value(sf, b));
      else if (sf == FMT_F32 || sf == FMT_C32) r = widen_f32(b[31:0]);
      else r = b;
      return r;
   endfunction

endpackage

### src/pixel_format_cast.sv
// Pixel element format cast: integer, real and complex formats, APB config.
//
// Converts one element per cycle from the source format to the target format
// set in the config registers (u8..s32, f32, f64, c32, c64; integer casts
// saturate, or shift with shift_mode set; reals clip and truncate to integers).
// An item is registered on entry, converted by one pass of combinational logic,
// and held in the result register; a new item is accepted every cycle unless
// the result side stalls. Write the config registers only while no item is in
// flight.
module pixel_format_cast (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_real_bits,
   input  logic [63:0] req_imag_bits,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_out_real_bits,
   output logic [63:0] rsp_out_imag_bits,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import pfc_pkg::*;

   logic [3:0]  src_fmt_ff, src_fmt_in;
   logic [3:0]  tgt_fmt_ff, tgt_fmt_in;
   logic        shift_ff, shift_in;
   logic        s1_valid_ff, s1_valid_in;
   logic [63:0] real_ff, real_in;
   logic [63:0] imag_ff, imag_in;
   logic        out_valid_ff, out_valid_in;
   logic [63:0] out_real_ff, out_real_in;
   logic [63:0] out_imag_ff, out_imag_in;
   logic        cfg_wr, s1_load, s2_load;
   logic        src_cplx, src_single;
   logic [63:0] dre, dim, cre, cim;

   // config port
   assign pready = 1'b1;
   assign cfg_wr = psel & penable & pwrite;

   always_comb begin
      src_fmt_in = src_fmt_ff;
      tgt_fmt_in = tgt_fmt_ff;
      shift_in   = shift_ff;
      if (cfg_wr) begin
         unique case (paddr[3:2])
            REG_SOURCE_FORMAT: src_fmt_in = pwdata[3:0];
            REG_TARGET_FORMAT: tgt_fmt_in = pwdata[3:0];
            REG_SHIFT_MODE:    shift_in   = pwdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[3:2])
         REG_SOURCE_FORMAT: prdata = {28'b0, src_fmt_ff};
         REG_TARGET_FORMAT: prdata = {28'b0, tgt_fmt_ff};
         REG_SHIFT_MODE:    prdata = {31'b0, shift_ff};
         default:           prdata = 32'b0;
      endcase
   end

   // handshake
   assign s2_load      = s1_valid_ff & (~out_valid_ff | ~rsp_stall);
   assign req_stall    = s1_valid_ff & ~s2_load;
   assign s1_load      = req_valid & ~req_stall;
   assign s1_valid_in  = s1_load | (s1_valid_ff & ~s2_load);
   assign out_valid_in = s2_load | (out_valid_ff & rsp_stall);
   assign real_in      = s1_load ? req_real_bits : real_ff;
   assign imag_in      = s1_load ? req_imag_bits : imag_ff;

   // conversion
   always_comb begin
      src_cplx   = src_fmt_ff == FMT_C32 || src_fmt_ff == FMT_C64;
      src_single = src_fmt_ff == FMT_F32 || src_fmt_ff == FMT_C32;
      dre = src_double(src_fmt_ff, real_ff);
      dim = src_double(src_fmt_ff, imag_ff);
      cre = 64'd0;
      cim = 64'd0;
      if (src_fmt_ff <= FMT_C64 && tgt_fmt_ff <= FMT_C64) begin
         if (src_fmt_ff == tgt_fmt_ff) begin
            if (src_fmt_ff < FMT_F32) cre = {32'b0, real_ff[31:0] & int_mask(src_fmt_ff)};
            else if (src_single) cre = {32'b0, real_ff[31:0]};
            else cre = real_ff;
            if (src_fmt_ff == FMT_C32) cim = {32'b0, imag_ff[31:0]};
            else if (src_fmt_ff == FMT_C64) cim = imag_ff;
         end else if (src_fmt_ff < FMT_F32 && tgt_fmt_ff < FMT_F32) begin
            cre = int_to_int(src_fmt_ff, tgt_fmt_ff, shift_ff, real_ff);
         end else if (tgt_fmt_ff < FMT_F32) begin
            cre = f64_to_int(dre, tgt_fmt_ff);
         end else if (tgt_fmt_ff == FMT_F32 || tgt_fmt_ff == FMT_C32) begin
            cre = {32'b0, src_single ? real_ff[31:0] : narrow_f64(dre)};
            if (tgt_fmt_ff == FMT_C32 && src_cplx)
               cim = {32'b0, src_single ? imag_ff[31:0] : narrow_f64(dim)};
         end else begin
            cre = dre;
            if (tgt_fmt_ff == FMT_C64 && src_cplx) cim = dim;
         end
      end
   end

   assign out_real_in = s2_load ? cre : out_real_ff;
   assign out_imag_in = s2_load ? cim : out_imag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_fmt_ff   <= FMT_U8;
         tgt_fmt_ff   <= FMT_U8;
         shift_ff     <= 1'b0;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         src_fmt_ff   <= src_fmt_in;
         tgt_fmt_ff   <= tgt_fmt_in;
         shift_ff     <= shift_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      real_ff     <= real_in;
      imag_ff     <= imag_in;
      out_real_ff <= out_real_in;
      out_imag_ff <= out_imag_in;
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_out_real_bits = out_real_ff;
   assign rsp_out_imag_bits = out_imag_ff;

endmodule
